// File: rtl/popvar_pkg.sv
// ----------------------------------------------------------------------------
// popvar_pkg
// shared widths and parameter defaults for the population variance block
// ----------------------------------------------------------------------------
package popvar_pkg;

   // parameter defaults
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int MAX_SAMPLES_DEF  = 65535;
   localparam int FRAC_BITS_DEF    = 8;

   // accumulator and result widths
   localparam int SUM_W = 32;
   localparam int SQ_W  = 47;
   localparam int CNT_W = 16;
   localparam int VAR_W = 38;

   // numerator n*s2 - s1^2 and denominator n*n
   localparam int NUM_W = 63;
   localparam int DEN_W = 32;

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // result stream: variance, sum, count, zero fill to whole bytes
   localparam int RSP_FIELDS_W = VAR_W + SUM_W + CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

// File: rtl/popvar_div.sv
// ----------------------------------------------------------------------------
// popvar_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module popvar_div #(
   parameter int DIVIDEND_W = 71
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIVIDEND_W-1:0]        dividend,
   input  logic [popvar_pkg::DEN_W-1:0] divisor,
   output logic                         done,
   output logic [DIVIDEND_W-1:0]        quotient
);

   localparam int DEN_W = popvar_pkg::DEN_W;
   localparam int CW    = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]      den_ff, den_in;

   logic [DEN_W:0]        shifted;
   logic [DEN_W+1:0]      trial;

   // shift the next dividend bit into the partial remainder and try a subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial[DEN_W+1]) begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/population_variance.sv
// ----------------------------------------------------------------------------
// population_variance
// running count, sum and sum of squares with exact fixed-point variance
// ----------------------------------------------------------------------------
// usage
//   req channel: one signed sample per request, tlast marks the final one
//   of a set. rsp channel: one result per set, holding
//   floor(((n*s2 - s1^2) << FRAC_BITS) / n^2) saturated to 38 bits, the
//   sum and the count; tuser flags a set that had samples dropped because
//   the count had reached MAX_SAMPLES.
//   per sample: a sample that does not close a set is accepted, squared on
//   the shared 32x32 multiplier and accumulated before the next is taken.
//   per set: the closing sample is followed by four more passes through
//   the shared multiplier (s1^2, two halves of n*s2, n^2), a compare, then
//   the divider at one quotient bit per cycle, before the result is valid.
//   a set whose numerator is not positive skips the divider.
//   req_tready is high only while the sequencer is idle.
//   stall: the result sits in an output register; the next set's samples
//   are still taken, and only a second result waits until the first is
//   taken.
//   reset: synchronous, clears the accumulators, the sequencer and the
//   output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module population_variance #(
   parameter int SAMPLE_WIDTH = popvar_pkg::SAMPLE_WIDTH_DEF,
   parameter int MAX_SAMPLES  = popvar_pkg::MAX_SAMPLES_DEF,
   parameter int FRAC_BITS    = popvar_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: sample in the low SAMPLE_WIDTH bits, zero fill above
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tlast,
   // response: variance_fixed, set_sum, set_count, zero fill
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [popvar_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // response user: overflowed
   output logic                                  rsp_tuser
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int SUM_W  = popvar_pkg::SUM_W;
   localparam int SQ_W   = popvar_pkg::SQ_W;
   localparam int CNT_W  = popvar_pkg::CNT_W;
   localparam int VAR_W  = popvar_pkg::VAR_W;
   localparam int NUM_W  = popvar_pkg::NUM_W;
   localparam int DEN_W  = popvar_pkg::DEN_W;
   localparam int MUL_W  = popvar_pkg::MUL_W;
   localparam int PROD_W = popvar_pkg::PROD_W;
   localparam int DIV_W  = NUM_W + FRAC_BITS;
   localparam int LO_W   = CNT_W + MUL_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR,
      ST_ACC,
      ST_S1SQ,
      ST_NS2LO,
      ST_NS2HI,
      ST_NN,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // accumulators
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;

   // captured request
   logic [SW-1:0]    mag_ff, mag_in;
   logic [SUM_W-1:0] sext_ff, sext_in;
   logic             last_ff, last_in;
   logic             take_ff, take_in;

   // final arithmetic
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_W-1:0]  s1sq_ff, s1sq_in;
   logic [LO_W-1:0]   lo_ff, lo_in;
   logic [NUM_W-1:0]  ns2_ff, ns2_in;
   logic [VAR_W-1:0]  var_ff, var_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAR_W-1:0]  rsp_var_ff, rsp_var_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [SW-1:0]     raw;
   logic [SUM_W-1:0]  s1_mag;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [NUM_W:0]    diff;
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic              div_done;
   logic [DIV_W-1:0]  div_quotient;
   logic              req_fire;
   logic              rsp_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign raw        = req_tdata[SW-1:0];

   // magnitude of the running sum, the most negative value maps to 2^31
   assign s1_mag = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQR: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = MUL_W'(mag_ff);
         end
         ST_S1SQ: begin
            mul_a = s1_mag;
            mul_b = s1_mag;
         end
         ST_NS2LO: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = sq_ff[MUL_W-1:0];
         end
         ST_NS2HI: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(sq_ff[SQ_W-1:MUL_W]);
         end
         ST_NN: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(cnt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // n*s2 minus s1^2, the top bit is the borrow
   assign diff         = {1'b0, ns2_ff} - {1'b0, s1sq_ff};
   assign div_dividend = DIV_W'(diff[NUM_W-1:0]) << FRAC_BITS;
   assign div_start    = (state_ff == ST_CMP) && (cnt_ff != '0) &&
                         !diff[NUM_W] && (diff[NUM_W-1:0] != '0);

   popvar_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (prod_ff[DEN_W-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      mag_in       = mag_ff;
      sext_in      = sext_ff;
      last_in      = last_ff;
      take_in      = take_ff;
      prod_in      = mul_a * mul_b;
      s1sq_in      = s1sq_ff;
      lo_in        = lo_ff;
      ns2_in       = ns2_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      rsp_var_in   = rsp_var_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // sign extension and magnitude of the raw sample
               sext_in  = {{(SUM_W-SW){raw[SW-1]}}, raw};
               mag_in   = raw[SW-1] ? (~raw + 1'b1) : raw;
               last_in  = req_tlast;
               take_in  = (cnt_ff < CNT_W'(MAX_SAMPLES));
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (take_ff) begin
               sum_in = sum_ff + sext_ff;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (take_ff) begin
               sq_in = sq_ff + prod_ff[SQ_W-1:0];
            end
            state_in = last_ff ? ST_S1SQ : ST_IDLE;
         end
         ST_S1SQ: begin
            state_in = ST_NS2LO;
         end
         ST_NS2LO: begin
            s1sq_in  = prod_ff[NUM_W-1:0];
            state_in = ST_NS2HI;
         end
         ST_NS2HI: begin
            lo_in    = prod_ff[LO_W-1:0];
            state_in = ST_NN;
         end
         ST_NN: begin
            // upper partial product lands 32 bits up
            ns2_in   = {prod_ff[NUM_W-MUL_W-1:0], {MUL_W{1'b0}}} + NUM_W'(lo_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (div_start) begin
               state_in = ST_DIV;
            end else begin
               // empty set or numerator not positive
               var_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_quotient[DIV_W-1:VAR_W] != '0) begin
                  var_in = '1;
               end else begin
                  var_in = div_quotient[VAR_W-1:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free, then start a new set
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_var_in   = var_ff;
               rsp_sum_in   = sum_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_ovf_in   = ovf_ff;
               sum_in       = '0;
               sq_in        = '0;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         sq_ff        <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff     <= mag_in;
      sext_ff    <= sext_in;
      last_ff    <= last_in;
      take_ff    <= take_in;
      prod_ff    <= prod_in;
      s1sq_ff    <= s1sq_in;
      lo_ff      <= lo_in;
      ns2_ff     <= ns2_in;
      var_ff     <= var_in;
      rsp_var_ff <= rsp_var_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = popvar_pkg::RSP_DATA_W'({rsp_cnt_ff, rsp_sum_ff, rsp_var_ff});
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for population_variance: sets of signed samples go in
// on the req stream, and every result on the rsp stream is compared field by
// field with a bit-exact fixed-point variance computed alongside
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SW         = popvar_pkg::SAMPLE_WIDTH_DEF;
   localparam int REQ_W      = ((SW + 7) / 8) * 8;
   localparam int SET_MAX    = popvar_pkg::MAX_SAMPLES_DEF;
   localparam int FRAC       = popvar_pkg::FRAC_BITS_DEF;
   localparam int VAR_W      = popvar_pkg::VAR_W;
   localparam int SUM_W      = popvar_pkg::SUM_W;
   localparam int SQ_W       = popvar_pkg::SQ_W;
   localparam int CNT_W      = popvar_pkg::CNT_W;
   localparam int RSP_DATA_W = popvar_pkg::RSP_DATA_W;
   localparam int N_RANDOM   = 1400;

   // one expected result per closed set
   typedef struct packed {
      logic [VAR_W-1:0] variance;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic             overflowed;
   } set_result_type;

   // running sums of the open set and the results still owed by the block
   class variance_tracker_type;
      logic [SUM_W-1:0] sum_acc;
      logic [SQ_W-1:0]  square_acc;
      logic [CNT_W-1:0] count_acc;
      logic             dropped;
      set_result_type   pending_results[$];
      int               failures;

      function new();
         sum_acc    = '0;
         square_acc = '0;
         count_acc  = '0;
         dropped    = 1'b0;
         failures   = 0;
      endfunction

      // floor(((n*s2 - s1^2) << FRAC) / n^2), saturated to the result width
      function logic [VAR_W-1:0] set_variance(logic [CNT_W-1:0] n, logic [SUM_W-1:0] s1,
                                             logic [SQ_W-1:0] s2);
         logic [63:0] mag, s1sq, ns2, num, den, q, r, top;
         top = (64'd1 << VAR_W) - 64'd1;
         if (n == '0)
            return '0;
         // two's complement magnitude, the most negative sum maps onto itself
         mag  = s1[SUM_W-1] ? {32'd0, -s1} : {32'd0, s1};
         s1sq = mag * mag;
         ns2  = 64'(n) * 64'(s2);
         if (ns2 <= s1sq)
            return '0;
         num = ns2 - s1sq;
         den = 64'(n) * 64'(n);
         q   = num / den;
         r   = num % den;
         if (q > top)
            return top[VAR_W-1:0];
         for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q = q | 64'd1;
            end
            if (q > top)
               return top[VAR_W-1:0];
         end
         return q[VAR_W-1:0];
      endfunction

      function void take_sample(logic [SW-1:0] raw, logic fin);
         logic [63:0] mag;
         set_result_type res;
         if (count_acc < SET_MAX) begin
            sum_acc    = sum_acc + {{(SUM_W-SW){raw[SW-1]}}, raw};
            mag        = raw[SW-1] ? ((64'd1 << SW) - 64'(raw)) : 64'(raw);
            square_acc = SQ_W'(64'(square_acc) + mag * mag);
            count_acc  = count_acc + 1'b1;
         end else begin
            dropped = 1'b1;
         end
         if (fin) begin
            res.variance   = set_variance(count_acc, sum_acc, square_acc);
            res.sum        = sum_acc;
            res.count      = count_acc;
            res.overflowed = dropped;
            pending_results.push_back(res);
            sum_acc    = '0;
            square_acc = '0;
            count_acc  = '0;
            dropped    = 1'b0;
         end
      endfunction

      function void check_result(logic [VAR_W-1:0] v, logic [SUM_W-1:0] s,
                                 logic [CNT_W-1:0] c, logic o);
         set_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: var=%0d sum=%0d cnt=%0d ovf=%0b",
                        v, $signed(s), c, o);
            return;
         end
         want = pending_results.pop_front();
         if (want.variance !== v || want.sum !== s || want.count !== c
             || want.overflowed !== o) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: exp var %0d sum %0d cnt %0d ovf %0b,",
                        want.variance, $signed(want.sum), want.count,
                        want.overflowed,
                        " got var %0d sum %0d cnt %0d ovf %0b",
                        v, $signed(s), c, o);
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;      // sample
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // variance_fixed, set_sum, set_count, fill
   logic              rsp_tuser;             // overflowed

   variance_tracker_type tracker = new();
   logic [SW-1:0]     set_values[$];
   bit                steady     = 1'b0;     // no request gaps and no new receiver stalls while set
   int                stall_left = 0;
   int                sent       = 0;

   population_variance u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // draw one sample of a set in the given style
   function automatic logic [SW-1:0] draw_sample(int style, logic [SW-1:0] base);
      case (style)
         0: return SW'($urandom);
         1: begin
            case ($urandom_range(0, 4))
               0: return {1'b1, {(SW-1){1'b0}}};     // most negative
               1: return {1'b0, {(SW-1){1'b1}}};     // most positive
               2: return '0;
               3: return '1;
               default: return SW'(1);
            endcase
         end
         2: return SW'($urandom_range(0, 8)) - SW'(4);
         3: return base;
         default: return base + SW'($urandom_range(0, 63)) - SW'(32);
      endcase
   endfunction

   // receiver: random stalls of varying length, no new ones while steady
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (steady || $urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   // results are checked at the rising edge they are taken on
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata[VAR_W-1:0],
                              rsp_tdata[VAR_W+SUM_W-1:VAR_W],
                              rsp_tdata[VAR_W+SUM_W+CNT_W-1:VAR_W+SUM_W],
                              rsp_tuser);
   end

   // one request, entered and left at a falling edge
   task automatic send_sample(input logic [SW-1:0] value, input logic fin, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(value);
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      tracker.take_sample(value, fin);
      sent++;
      @(negedge clock);
   endtask

   // send set_values as one set, tlast on the final sample
   task automatic send_set();
      for (int i = 0; i < set_values.size(); i++)
         send_sample(set_values[i], i == set_values.size() - 1, steady ? 0 : pick_gap());
   endtask

   initial begin : stimulus
      int            len;
      int            style;
      logic [SW-1:0] base;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single sample sets at both extremes: n = 1, variance zero
      set_values = '{16'h8000};
      send_set();
      set_values = '{16'h7fff};
      send_set();
      // quarter variance, only fraction bits set
      set_values = '{16'h0000, 16'h0001};
      send_set();
      // widest possible spread
      set_values = '{16'h8000, 16'h7fff};
      send_set();
      // fraction that does not end in the fraction bits
      set_values = '{16'h0000, 16'h0000, 16'h0001};
      send_set();
      // constant sets, negative sum
      set_values = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
      send_set();
      set_values = '{16'h8000, 16'h8000, 16'h8000};
      send_set();
      // mixed signs
      set_values = '{16'd5, 16'hfffd, 16'd12, 16'hfff9, 16'd100};
      send_set();
      // back to back set with no request gaps and no new receiver stalls
      steady = 1'b1;
      set_values = '{16'h1234, 16'hedcb, 16'h0042};
      send_set();
      steady = 1'b0;

      // random sets, mostly short, a few long, with random styles of content
      sent = 0;
      while (sent < N_RANDOM) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: len = $urandom_range(1, 8);
            10, 11, 12, 13, 14, 15, 16:   len = $urandom_range(9, 40);
            default:                      len = $urandom_range(41, 200);
         endcase
         style  = $urandom_range(0, 4);
         base   = SW'($urandom);
         steady = ($urandom_range(0, 9) == 0);
         set_values.delete();
         for (int i = 0; i < len; i++)
            set_values.push_back(draw_sample(style, base));
         send_set();
      end
      steady     = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then allow for a divider pass still in flight
      while (tracker.pending_results.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);

      if (tracker.failures == 0 && tracker.pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // overall time limit, several times the slowest legal run
   initial begin
      #15000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
